### sv/stam_pkg.sv
`timescale 1ns / 1ps
package stam_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int ADDR_BITS  = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int PT_BITS    = 32;

  typedef logic signed [PT_BITS-1:0] pt_t;
  typedef logic [ADDR_BITS-1:0]      addr_t;
  typedef logic [CNT_BITS-1:0]       cnt_t;

  // heap operation codes
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_PUSHPOP = 2'd1
  } heap_op_t;

  // request to one heap engine
  typedef struct packed {
    logic     start;
    heap_op_t op;
    cnt_t     n;
    pt_t      x;
  } heap_req_t;

  typedef struct packed {
    logic done;
    pt_t  res;
    pt_t  top;
  } heap_rsp_t;

  // saturating signed 64-bit add
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] s,
                                                 input logic signed [63:0] d);
    logic signed [63:0] r;
    r = s + d;
    if (!s[63] && !d[63] && r[63]) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s[63] && d[63] && !r[63]) return 64'sh8000_0000_0000_0000;
    return r;
  endfunction
endpackage

### sv/stam_if.sv
`timescale 1ns / 1ps
interface stam_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] point;
  logic [31:0] offset;
  modport source (output valid, point, offset, input ready);
  modport sink (input valid, point, offset, output ready);
endinterface

interface stam_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] argmin;
  logic [63:0] min_value;
  logic        full_res;
  modport source (output valid, argmin, min_value, full_res, input ready);
  modport sink (input valid, argmin, min_value, full_res, output ready);
endinterface

### sv/stam_heap.sv
`timescale 1ns / 1ps
// Min-heap in one memory, one read or write per cycle.
// 'inv' flips the ordering so the same engine serves as a max-heap.
// Push: sift up from index n, one parent read and one write a level.
// Push-pop: if x goes behind the root, the root is returned and x is
// sifted down from the root a level at a time; otherwise x is returned.
module stam_heap import stam_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      inv,
  input  heap_req_t req,
  output heap_rsp_t rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_RTOP, S_RTOP_CMP, S_DN_RD1, S_DN_RD2,
    S_DN_CMP, S_WR, S_DONE
  } state_t;

  pt_t mem [MAX_POINTS];
  state_t state_r;
  cnt_t n_r;
  pt_t x_r, res_r, top_r, c1_r, q_r;
  addr_t i_r;
  addr_t rd_addr;
  logic  rd_en, wr_en;
  addr_t wr_addr;
  pt_t   wr_data;
  logic [CNT_BITS:0] cl, cr, n_ext, kid_cl;
  addr_t par;
  logic  has2, take2;
  pt_t   kid_val;
  addr_t kid_idx;

  // ordering compare with optional inversion
  function automatic logic lt(input pt_t a, input pt_t b, input logic v);
    return v ? (b < a) : (a < b);
  endfunction

  // child and parent indexes of the current slot
  assign cl    = {1'b0, i_r, 1'b1};
  assign cr    = cl + 1'b1;
  assign n_ext = {1'b0, n_r};
  assign par   = (i_r - 1'b1) >> 1;

  // c1_r holds the first child, q_r the second (when present)
  assign has2    = (cr < n_ext);
  assign take2   = has2 && lt(q_r, c1_r, inv);
  assign kid_val = take2 ? q_r : c1_r;
  assign kid_idx = take2 ? cr[ADDR_BITS-1:0] : cl[ADDR_BITS-1:0];
  assign kid_cl  = {1'b0, kid_idx, 1'b1};

  // memory port, registered read; root value tracked on every write to 0
  always_ff @(posedge clk) begin
    if (rd_en) q_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
    if (wr_en && wr_addr == '0) top_r <= wr_data;
  end

  always_comb begin
    rd_en = 1'b0; rd_addr = i_r; wr_en = 1'b0; wr_addr = i_r; wr_data = x_r;
    unique case (state_r)
      S_UP_RD: begin rd_en = 1'b1; rd_addr = par; end
      S_UP_CMP: begin
        wr_en = 1'b1;
        wr_data = lt(x_r, q_r, inv) ? q_r : x_r;
      end
      S_RTOP: begin rd_en = 1'b1; rd_addr = '0; end
      S_DN_RD1: begin rd_en = 1'b1; rd_addr = cl[ADDR_BITS-1:0]; end
      S_DN_RD2: begin rd_en = has2; rd_addr = cr[ADDR_BITS-1:0]; end
      S_DN_CMP: begin
        wr_en = 1'b1;
        wr_data = lt(kid_val, x_r, inv) ? kid_val : x_r;
      end
      S_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (req.start) begin
          n_r <= req.n; x_r <= req.x; res_r <= req.x;
          if (req.op == OP_PUSH) begin
            i_r <= req.n[ADDR_BITS-1:0];
            state_r <= (req.n == '0) ? S_WR : S_UP_RD;
          end else begin
            i_r <= '0;
            state_r <= (req.n == '0) ? S_DONE : S_RTOP;
          end
        end
        S_UP_RD: state_r <= S_UP_CMP;
        S_UP_CMP: begin
          if (lt(x_r, q_r, inv)) begin
            i_r <= par;
            state_r <= (par == '0) ? S_WR : S_UP_RD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_RTOP: state_r <= S_RTOP_CMP;
        S_RTOP_CMP: begin
          // root replaced only when x goes behind it
          if (lt(q_r, x_r, inv)) begin
            res_r <= q_r;
            state_r <= (cl >= n_ext) ? S_WR : S_DN_RD1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DN_RD1: state_r <= S_DN_RD2;
        S_DN_RD2: begin
          c1_r <= q_r;
          state_r <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (lt(kid_val, x_r, inv)) begin
            i_r <= kid_idx;
            state_r <= (kid_cl >= n_ext) ? S_WR : S_DN_RD1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_WR: state_r <= S_DONE;
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = (state_r == S_DONE);
  assign rsp.res  = res_r;
  assign rsp.top  = top_r;
endmodule

### sv/slope_trick_abs_minimum_unit.sv
`timescale 1ns / 1ps
// Slope-trick minimum tracker.
// in channel: point and offset of a new |x - point| + offset term.
// out channel: argmin, saturating min_value and full_res, one per request.
// One request runs four heap operations in sequence, a push-pop and a push
// on each of two heap engines, each a sift over one memory port: up to 10
// levels, up or down; a request that comes when full skips the heap
// operations. in_ready is low while a request is in work or its result
// waits.
// The result is held in an output register until out_ready; a stalled
// receiver holds off the next request.
// Reset clears the count and minimum; heap memories need no clearing,
// as only entries below the count are ever read. Once 1024 points are
// stored, further requests leave the state alone and report full_res.
module slope_trick_abs_minimum_unit import stam_pkg::*; (
  input logic clk,
  input logic rst_n,
  stam_in_if.sink    in_if,
  stam_out_if.source out_if
);
  typedef enum logic [2:0] {S_IDLE, S_L1, S_R1, S_R2, S_L2, S_OUT} state_t;
  state_t state_r;
  heap_req_t lreq, rreq;
  heap_rsp_t lrsp, rrsp;
  cnt_t cnt_r;
  pt_t p_r, t_r;
  logic signed [63:0] sum_r;
  logic full_r, go_r;

  stam_heap u_left (.clk, .rst_n, .inv(1'b1), .req(lreq), .rsp(lrsp));
  stam_heap u_right (.clk, .rst_n, .inv(1'b0), .req(rreq), .rsp(rrsp));

  logic signed [63:0] inc;
  pt_t pin;
  assign pin = pt_t'(in_if.point);
  always_comb begin
    inc = {{32{in_if.offset[31]}}, in_if.offset};
    if (cnt_r != '0) begin
      if (lrsp.top > pin) inc = inc + (64'(lrsp.top) - 64'(pin));
      if (pin > rrsp.top) inc = inc + (64'(pin) - 64'(rrsp.top));
    end
  end

  always_comb begin
    lreq = '0; rreq = '0;
    lreq.n = cnt_r; rreq.n = cnt_r;
    unique case (state_r)
      S_L1: begin lreq.start = go_r; lreq.op = OP_PUSHPOP; lreq.x = p_r; end
      S_R1: begin rreq.start = go_r; rreq.op = OP_PUSH; rreq.x = t_r; end
      S_R2: begin rreq.start = go_r; rreq.op = OP_PUSHPOP; rreq.x = p_r;
                  rreq.n = cnt_r + 1'b1; end
      S_L2: begin lreq.start = go_r; lreq.op = OP_PUSH; lreq.x = t_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; sum_r <= '0; go_r <= 1'b0; full_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_if.valid) begin
          p_r <= pin;
          if (cnt_r == cnt_t'(MAX_POINTS)) begin
            full_r <= 1'b1; state_r <= S_OUT;
          end else begin
            full_r <= 1'b0; sum_r <= sat_add(sum_r, inc);
            go_r <= 1'b1; state_r <= S_L1;
          end
        end
        S_L1: if (lrsp.done) begin t_r <= lrsp.res; go_r <= 1'b1; state_r <= S_R1; end
        S_R1: if (rrsp.done) begin go_r <= 1'b1; state_r <= S_R2; end
        S_R2: if (rrsp.done) begin t_r <= rrsp.res; go_r <= 1'b1; state_r <= S_L2; end
        S_L2: if (lrsp.done) begin cnt_r <= cnt_r + 1'b1; state_r <= S_OUT; end
        S_OUT: if (out_if.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready      = (state_r == S_IDLE);
  assign out_if.valid     = (state_r == S_OUT);
  assign out_if.argmin    = (cnt_r == '0) ? 32'h8000_0000 : lrsp.top;
  assign out_if.min_value = sum_r;
  assign out_if.full_res  = full_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(MAX_POINTS)) else $error("count overflow");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid)) else $error("ready while result held");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.full_res |-> cnt_r == cnt_t'(MAX_POINTS))
    else $error("full flag without full heaps");
endmodule
